// ===== src/lpmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpmf_pkg;

  localparam int unsigned LenW  = 10;
  localparam int unsigned ByteW = 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_POPPED    = 3'd2,
    ST_POP_EMPTY = 3'd3,
    ST_EMPTY_MSG = 3'd4
  } status_e;

  typedef struct packed {
    logic             opcode;
    logic [ByteW-1:0] data_in;
    logic [LenW-1:0]  msg_length;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ByteW-1:0] data_out;
    logic             last;
    logic [LenW-1:0]  popped_length;
    logic [LenW-1:0]  used_bytes;
    logic [LenW-1:0]  free_bytes;
    logic             full_res;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_HDR_WR,
    S_PAY_WR,
    S_HDR_RD0,
    S_HDR_RD1,
    S_HDR_CHK,
    S_POP_REQ,
    S_POP_DATA,
    S_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    wr_en;
    logic    wr_hdr;
    logic    wr_adv;
    logic    cnt_inc;
    logic    push_set;
    logic    push_dec;
    logic    rd_en;
    logic    rd_off1;
    logic    hdr_lo_we;
    logic    hdr_hi_we;
    logic    rd_adv_hdr;
    logic    pop_set;
    logic    pop_data;
    logic    st_we;
    status_e st_code;
    logic    last_set;
    logic    emit;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic push_open;
    logic pop_open;
    logic room;
    logic len_zero;
    logic cnt_last;
    logic used_zero;
    logic used_lt_hdr;
    logic used_lt_hdr1;
    logic hdr_zero;
  } sts_t;

  // Little-endian header byte of a message length
  function automatic logic [ByteW-1:0] hdr_byte(logic [LenW-1:0] len, logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = len[7:0];
      2'd1:    b = {6'b0, len[9:8]};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/lpmf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpmf_ctrl #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire lpmf_pkg::sts_t sts_i,
  output lpmf_pkg::ctl_t     ctl_o
);

  lpmf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpmf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != lpmf_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpmf_pkg::S_IDLE: begin
        if (start_i) state_d = lpmf_pkg::S_EVAL;
      end
      lpmf_pkg::S_EVAL: begin
        if (!sts_i.is_pop) begin
          if (sts_i.push_open || !sts_i.room) state_d = lpmf_pkg::S_DONE;
          else state_d = lpmf_pkg::S_HDR_WR;
        end else if (sts_i.pop_open) begin
          if (sts_i.used_zero) state_d = lpmf_pkg::S_DONE;
          else state_d = lpmf_pkg::S_POP_REQ;
        end else if (sts_i.used_lt_hdr) begin
          state_d = lpmf_pkg::S_DONE;
        end else begin
          state_d = lpmf_pkg::S_HDR_RD0;
        end
      end
      lpmf_pkg::S_HDR_WR: begin
        if (sts_i.cnt_last) begin
          if (sts_i.len_zero) state_d = lpmf_pkg::S_DONE;
          else state_d = lpmf_pkg::S_PAY_WR;
        end
      end
      lpmf_pkg::S_PAY_WR: state_d = lpmf_pkg::S_DONE;
      lpmf_pkg::S_HDR_RD0: begin
        if (HEADER_BYTES >= 2) state_d = lpmf_pkg::S_HDR_RD1;
        else state_d = lpmf_pkg::S_HDR_CHK;
      end
      lpmf_pkg::S_HDR_RD1: state_d = lpmf_pkg::S_HDR_CHK;
      lpmf_pkg::S_HDR_CHK: begin
        if (sts_i.hdr_zero || sts_i.used_lt_hdr1) state_d = lpmf_pkg::S_DONE;
        else state_d = lpmf_pkg::S_POP_REQ;
      end
      lpmf_pkg::S_POP_REQ:  state_d = lpmf_pkg::S_POP_DATA;
      lpmf_pkg::S_POP_DATA: state_d = lpmf_pkg::S_DONE;
      lpmf_pkg::S_DONE:     state_d = lpmf_pkg::S_IDLE;
      default:              state_d = lpmf_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctl_o         = '0;
    ctl_o.st_code = lpmf_pkg::ST_PUSHED;
    case (state_q)
      lpmf_pkg::S_IDLE: begin
        ctl_o.load = start_i;
      end
      lpmf_pkg::S_EVAL: begin
        if (!sts_i.is_pop) begin
          if (sts_i.push_open) begin
            ctl_o.wr_en    = 1'b1;
            ctl_o.wr_adv   = 1'b1;
            ctl_o.push_dec = 1'b1;
            ctl_o.st_we    = 1'b1;
            ctl_o.st_code  = lpmf_pkg::ST_PUSHED;
          end else if (!sts_i.room) begin
            ctl_o.st_we   = 1'b1;
            ctl_o.st_code = lpmf_pkg::ST_REFUSED;
          end
        end else if (sts_i.pop_open) begin
          if (sts_i.used_zero) begin
            ctl_o.st_we   = 1'b1;
            ctl_o.st_code = lpmf_pkg::ST_POP_EMPTY;
          end
        end else if (sts_i.used_lt_hdr) begin
          ctl_o.st_we   = 1'b1;
          ctl_o.st_code = lpmf_pkg::ST_POP_EMPTY;
        end else begin
          ctl_o.rd_en = 1'b1;
        end
      end
      lpmf_pkg::S_HDR_WR: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_hdr  = 1'b1;
        ctl_o.wr_adv  = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last && sts_i.len_zero) begin
          ctl_o.st_we   = 1'b1;
          ctl_o.st_code = lpmf_pkg::ST_PUSHED;
        end
      end
      lpmf_pkg::S_PAY_WR: begin
        ctl_o.wr_en    = 1'b1;
        ctl_o.wr_adv   = 1'b1;
        ctl_o.push_set = 1'b1;
        ctl_o.st_we    = 1'b1;
        ctl_o.st_code  = lpmf_pkg::ST_PUSHED;
      end
      lpmf_pkg::S_HDR_RD0: begin
        ctl_o.hdr_lo_we = 1'b1;
        if (HEADER_BYTES >= 2) begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_off1 = 1'b1;
        end
      end
      lpmf_pkg::S_HDR_RD1: begin
        ctl_o.hdr_hi_we = 1'b1;
      end
      lpmf_pkg::S_HDR_CHK: begin
        if (!sts_i.hdr_zero && sts_i.used_lt_hdr1) begin
          ctl_o.st_we   = 1'b1;
          ctl_o.st_code = lpmf_pkg::ST_POP_EMPTY;
        end else begin
          ctl_o.rd_adv_hdr = 1'b1;
          ctl_o.pop_set    = 1'b1;
          if (sts_i.hdr_zero) begin
            ctl_o.st_we    = 1'b1;
            ctl_o.st_code  = lpmf_pkg::ST_EMPTY_MSG;
            ctl_o.last_set = 1'b1;
          end
        end
      end
      lpmf_pkg::S_POP_REQ: begin
        ctl_o.rd_en = 1'b1;
      end
      lpmf_pkg::S_POP_DATA: begin
        ctl_o.pop_data = 1'b1;
        ctl_o.st_we    = 1'b1;
        ctl_o.st_code  = lpmf_pkg::ST_POPPED;
      end
      lpmf_pkg::S_DONE: begin
        ctl_o.emit = 1'b1;
      end
      default: begin
        ctl_o.st_code = lpmf_pkg::ST_PUSHED;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lpmf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpmf_dp #(
  parameter int unsigned RING_BYTES   = 1024,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lpmf_pkg::in_t  item_i,
  input  wire lpmf_pkg::ctl_t ctl_i,
  output lpmf_pkg::sts_t      sts_o,
  output logic                strobe_o,
  output lpmf_pkg::out_t      result_o
);

  localparam int unsigned AW   = $clog2(RING_BYTES);
  localparam int unsigned CW   = ((AW > lpmf_pkg::LenW) ? AW : lpmf_pkg::LenW) + 1;
  localparam int unsigned CntW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned LenW = lpmf_pkg::LenW;

  logic [7:0] ring_mem [RING_BYTES];
  logic [7:0] rdata_q;

  lpmf_pkg::in_t    item_q;
  logic [AW-1:0]    wr_q, rd_q;
  logic [LenW-1:0]  push_left_q, pop_left_q, pop_len_q;
  logic [CntW-1:0]  cnt_q;
  logic [7:0]       hdr_lo_q;
  logic [1:0]       hdr_hi_q;
  lpmf_pkg::status_e status_q;
  logic [7:0]       dout_q;
  logic             last_q;
  lpmf_pkg::out_t   res_q;
  logic             strobe_q;

  logic [AW-1:0]    used, free_cnt, rd_addr;
  logic [CW-1:0]    used_w, free_w, need_w;
  logic [LenW-1:0]  hdr_len;
  logic [7:0]       wdata;
  logic             fits;

  assign used     = wr_q - rd_q;
  assign free_cnt = ~used;
  assign used_w   = CW'(used);
  assign free_w   = CW'(free_cnt);
  assign need_w   = CW'(item_q.msg_length) + CW'(HEADER_BYTES);
  assign hdr_len  = {hdr_hi_q, hdr_lo_q};
  assign fits     = (HEADER_BYTES >= 2) || (item_q.msg_length[9:8] == 2'b00);
  assign rd_addr  = rd_q + AW'(ctl_i.rd_off1);
  assign wdata    = ctl_i.wr_hdr ? lpmf_pkg::hdr_byte(item_q.msg_length, 2'(cnt_q))
                                 : item_q.data_in;

  always_comb begin
    sts_o.is_pop       = (item_q.opcode == lpmf_pkg::OP_POP);
    sts_o.push_open    = (push_left_q != '0);
    sts_o.pop_open     = (pop_left_q != '0);
    sts_o.room         = fits && (need_w <= free_w);
    sts_o.len_zero     = (item_q.msg_length == '0);
    sts_o.cnt_last     = (cnt_q == CntW'(HEADER_BYTES - 1));
    sts_o.used_zero    = (used == '0);
    sts_o.used_lt_hdr  = (used_w < CW'(HEADER_BYTES));
    sts_o.used_lt_hdr1 = (used_w < CW'(HEADER_BYTES + 1));
    sts_o.hdr_zero     = (hdr_len == '0);
  end

  // Ring memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      ring_mem[wr_q] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= ring_mem[rd_addr];
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q   <= item_i;
      hdr_lo_q <= '0;
      hdr_hi_q <= '0;
      dout_q   <= '0;
      last_q   <= 1'b0;
      status_q <= lpmf_pkg::ST_PUSHED;
    end else begin
      if (ctl_i.hdr_lo_we) hdr_lo_q <= rdata_q;
      if (ctl_i.hdr_hi_we) hdr_hi_q <= rdata_q[1:0];
      if (ctl_i.st_we) status_q <= ctl_i.st_code;
      if (ctl_i.last_set) last_q <= 1'b1;
      if (ctl_i.pop_data) begin
        dout_q <= rdata_q;
        last_q <= (pop_left_q == LenW'(1));
      end
    end
    if (ctl_i.emit) begin
      res_q.status        <= status_q;
      res_q.data_out      <= dout_q;
      res_q.last          <= last_q;
      res_q.popped_length <= pop_len_q;
      res_q.used_bytes    <= used_w[LenW-1:0];
      res_q.free_bytes    <= free_w[LenW-1:0];
      res_q.full_res      <= ((wr_q + AW'(1)) == rd_q);
    end
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      push_left_q <= '0;
      pop_left_q  <= '0;
      pop_len_q   <= '0;
      cnt_q       <= '0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= ctl_i.emit;
      if (ctl_i.load) begin
        cnt_q <= '0;
      end else if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (ctl_i.wr_adv) wr_q <= wr_q + AW'(1);
      if (ctl_i.rd_adv_hdr) begin
        rd_q <= rd_q + AW'(HEADER_BYTES);
      end else if (ctl_i.pop_data) begin
        rd_q <= rd_q + AW'(1);
      end
      if (ctl_i.push_set) begin
        push_left_q <= item_q.msg_length - LenW'(1);
      end else if (ctl_i.push_dec) begin
        push_left_q <= push_left_q - LenW'(1);
      end
      if (ctl_i.pop_set) begin
        pop_left_q <= hdr_len;
        pop_len_q  <= hdr_len;
      end else if (ctl_i.pop_data) begin
        pop_left_q <= pop_left_q - LenW'(1);
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== src/length_prefixed_message_fifo_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed message FIFO: a byte ring of RING_BYTES entries holding
// messages stored as a HEADER_BYTES little-endian length plus payload.
// Command channel: drive item_i and raise start_i; the word is taken at a
// clock edge where start_i is high and busy_o is low. item_i.opcode selects
// push (one payload byte, msg_length read on the word that opens a message)
// or pop (one payload byte, last marked on the final byte of its message).
// Result channel: strobe_o is high for exactly one cycle with result_o
// holding status, popped byte, length of the message being popped and the
// used/free counts after the word. The receiver cannot stall; every result
// must be taken in the cycle it is shown.
// Each word keeps busy_o high until its result is reported, so a new word
// is taken only once the last one is through. The result strobe rises in
// the cycle busy_o falls. The pace is set by the ring memory: one write
// port stepping through header bytes and a registered read port.
// Reset empties the ring and closes any open push or pop message; memory
// contents are not cleared and need no clearing pass.

module length_prefixed_message_fifo_unit #(
  parameter int unsigned RING_BYTES   = 1024,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire lpmf_pkg::in_t item_i,
  output logic               strobe_o,
  output lpmf_pkg::out_t     result_o
);

  lpmf_pkg::ctl_t ctl;
  lpmf_pkg::sts_t sts;

  // Sequence each word: decide, step header bytes, then report
  lpmf_ctrl #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // Hold ring memory, indices, open-message counts and result register
  lpmf_dp #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== sim/length_prefixed_message_fifo_unit_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_message_fifo_unit_tb;

  localparam int unsigned RingBytes = 1024;
  localparam int unsigned HdrBytes  = 4;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned ByteW     = lpmf_pkg::ByteW;
  localparam int unsigned LenW      = lpmf_pkg::LenW;
  localparam int unsigned MaxLen    = 1019;
  localparam int unsigned Limit     = 400000;

  // Mirror of the ring: byte store, both indexes, the open push and pop
  // messages, and the results still owed by the block.
  class ring_scoreboard;
    logic [ByteW-1:0] ring [RingBytes];
    logic [IdxW-1:0]  wr_idx;
    logic [IdxW-1:0]  rd_idx;
    logic [LenW-1:0]  push_left;
    logic [LenW-1:0]  pop_left;
    logic [LenW-1:0]  pop_len;
    lpmf_pkg::out_t   owed_results [$];
    int unsigned      mismatches;

    function new();
      wr_idx     = '0;
      rd_idx     = '0;
      push_left  = '0;
      pop_left   = '0;
      pop_len    = '0;
      mismatches = 0;
    endfunction

    function logic [IdxW-1:0] used_count();
      logic [IdxW-1:0] u;
      u = wr_idx - rd_idx;
      return u;
    endfunction

    function int unsigned free_count();
      return RingBytes - 1 - used_count();
    endfunction

    // Work out the result of one accepted word and queue it.
    function void take_word(lpmf_pkg::in_t w);
      lpmf_pkg::out_t    r;
      lpmf_pkg::status_e st;
      logic [ByteW-1:0]  dout;
      logic              is_last;
      logic [LenW-1:0]   hdr;
      logic [IdxW-1:0]   slot;
      logic [31:0]       wide_len;
      st       = lpmf_pkg::ST_PUSHED;
      dout     = '0;
      is_last  = 1'b0;
      wide_len = 32'(w.msg_length);
      if (w.opcode == lpmf_pkg::OP_PUSH) begin
        if (push_left != 0) begin
          ring[wr_idx] = w.data_in;
          wr_idx++;
          push_left--;
        end else if (w.msg_length + HdrBytes > free_count()) begin
          st = lpmf_pkg::ST_REFUSED;
        end else begin
          // a 10-bit length always fits a four-byte header
          for (int i = 0; i < HdrBytes; i++) begin
            slot       = wr_idx + IdxW'(i);
            ring[slot] = wide_len[8*i +: 8];
          end
          wr_idx = wr_idx + IdxW'(HdrBytes);
          if (w.msg_length != 0) begin
            ring[wr_idx] = w.data_in;
            wr_idx++;
            push_left = w.msg_length - LenW'(1);
          end
        end
      end else begin
        if (pop_left != 0) begin
          if (used_count() == 0) begin
            st = lpmf_pkg::ST_POP_EMPTY;
          end else begin
            dout = ring[rd_idx];
            rd_idx++;
            pop_left--;
            is_last = (pop_left == 0);
            st      = lpmf_pkg::ST_POPPED;
          end
        end else if (used_count() < HdrBytes) begin
          st = lpmf_pkg::ST_POP_EMPTY;
        end else begin
          slot = rd_idx + IdxW'(1);
          hdr  = {ring[slot][1:0], ring[rd_idx]};
          if (hdr != 0 && used_count() < HdrBytes + 1) begin
            st = lpmf_pkg::ST_POP_EMPTY;
          end else begin
            rd_idx  = rd_idx + IdxW'(HdrBytes);
            pop_len = hdr;
            if (hdr == 0) begin
              st      = lpmf_pkg::ST_EMPTY_MSG;
              is_last = 1'b1;
            end else begin
              dout = ring[rd_idx];
              rd_idx++;
              pop_left = hdr - LenW'(1);
              is_last  = (pop_left == 0);
              st       = lpmf_pkg::ST_POPPED;
            end
          end
        end
      end
      slot            = wr_idx + IdxW'(1);
      r.status        = st;
      r.data_out      = dout;
      r.last          = is_last;
      r.popped_length = pop_len;
      r.used_bytes    = used_count();
      r.free_bytes    = LenW'(free_count());
      r.full_res      = (slot == rd_idx);
      owed_results.push_back(r);
    endfunction

    function void check_field(string fld, logic [LenW-1:0] want, logic [LenW-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0d, got %0d", fld, want, got);
      end
    endfunction

    function void check_result(lpmf_pkg::out_t got);
      lpmf_pkg::out_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %0d", got.status, got.data_out);
        return;
      end
      want = owed_results.pop_front();
      check_field("status", LenW'(want.status), LenW'(got.status));
      check_field("data_out", LenW'(want.data_out), LenW'(got.data_out));
      check_field("last", LenW'(want.last), LenW'(got.last));
      check_field("popped_length", want.popped_length, got.popped_length);
      check_field("used_bytes", want.used_bytes, got.used_bytes);
      check_field("free_bytes", want.free_bytes, got.free_bytes);
      check_field("full_res", LenW'(want.full_res), LenW'(got.full_res));
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  lpmf_pkg::in_t  item_i;
  logic           strobe_o;
  lpmf_pkg::out_t result_o;

  ring_scoreboard sb;
  int unsigned    gap_pct;
  int unsigned    cycle_count = 0;

  length_prefixed_message_fifo_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Take every result in the cycle it is shown.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer a word and hold it until the block takes it.
  task automatic send_word(lpmf_pkg::in_t w);
    item_i  <= w;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.take_word(w);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic push_word(logic [ByteW-1:0] data, logic [LenW-1:0] len);
    lpmf_pkg::in_t w;
    w.opcode     = lpmf_pkg::OP_PUSH;
    w.data_in    = data;
    w.msg_length = len;
    send_word(w);
    sender_gap();
  endtask

  task automatic pop_word();
    lpmf_pkg::in_t w;
    w.opcode     = lpmf_pkg::OP_POP;
    w.data_in    = ByteW'($urandom_range(0, 255));
    w.msg_length = LenW'($urandom_range(0, MaxLen));
    send_word(w);
    sender_gap();
  endtask

  // Mostly short messages; fill the ring exactly now and then when close to full.
  task automatic random_traffic(int unsigned n_words);
    bit          filling;
    int unsigned pick;
    int unsigned room;
    logic [LenW-1:0] len;
    filling = 1'b1;
    for (int k = 0; k < n_words; k++) begin
      if (sb.used_count() > 600) filling = 1'b0;
      else if (sb.used_count() < 20) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      if ($urandom_range(0, 99) < (filling ? 80 : 20)) begin
        len = LenW'($urandom_range(0, MaxLen));
        if (sb.push_left == 0) begin
          room = sb.free_count();
          pick = $urandom_range(0, 99);
          if (filling && room >= HdrBytes && room < 48 && pick < 50)
            len = LenW'(room - HdrBytes);
          else if (pick < 60) len = LenW'($urandom_range(0, 6));
          else if (pick < 85) len = LenW'($urandom_range(7, 40));
          else if (pick < 95) len = LenW'($urandom_range(41, 200));
        end
        push_word(ByteW'($urandom_range(0, 255)), len);
      end else begin
        pop_word();
      end
    end
  endtask

  // Drain, then fill the ring to its last byte with one short message and
  // empty ones, try two pushes on the full ring and drain it again.
  task automatic whole_ring_message();
    while (sb.push_left != 0)
      push_word(ByteW'($urandom_range(0, 255)), LenW'($urandom_range(0, MaxLen)));
    while (sb.used_count() != 0) pop_word();
    push_word(8'h11, 10'd3);
    push_word(8'h22, LenW'(MaxLen));
    push_word(8'h33, 10'd0);
    while (sb.free_count() != 0) push_word(ByteW'($urandom_range(0, 255)), 10'd0);
    push_word(8'h00, 10'd0);
    push_word(8'hFF, LenW'(MaxLen));
    while (sb.used_count() != 0) pop_word();
    pop_word();
  endtask

  initial begin
    sb = new();
    gap_pct = 0;
    start_i <= 1'b0;
    item_i  <= '0;
    rst_ni  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty ring, empty message, partly pushed message,
    // ignored length on payload bytes, refusal for lack of room.
    pop_word();
    push_word(8'hFF, 10'd0);
    pop_word();
    pop_word();
    push_word(8'h00, 10'd3);
    push_word(8'hFF, LenW'(MaxLen));
    pop_word();
    pop_word();
    pop_word();
    push_word(8'hA5, 10'd0);
    pop_word();
    push_word(8'h80, 10'd1);
    push_word(8'h7F, LenW'(MaxLen));
    pop_word();
    push_word(8'h55, 10'd0);
    push_word(8'h01, 10'd2);
    push_word(8'h02, 10'd512);
    pop_word();
    pop_word();
    pop_word();
    pop_word();
    whole_ring_message();

    gap_pct = 37;
    random_traffic(220);
    gap_pct = 61;
    random_traffic(220);
    gap_pct = 0;
    random_traffic(220);

    start_i <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
